### rtl/hll_pkg.sv
package hll_pkg;

	localparam int MaxIndexBits = 10;
	localparam int RankW = 7;
	localparam int SumW = 75;
	localparam logic [3:0] IndexBitsReset = 4'd10;
	localparam logic [15:0] AlphaReset = 16'd52036;

	localparam logic CmdAdd = 1'b0;
	localparam logic CmdEstimate = 1'b1;

	localparam logic RegIndexBits = 1'b0;
	localparam logic RegAlpha = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] key_hash;
	} hll_in_t;

	typedef struct packed {
		logic [63:0] estimate;
		logic        saturated;
	} hll_out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} hll_state_t;

	// Rank of the bits left after the index: leading zeros plus one, 64 when all zero.
	function automatic logic [RankW-1:0] rank_of(input logic [63:0] rest);
		logic [RankW-1:0] r;
		r = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (rest[i]) r = 7'(64 - i);
		end
		return r;
	endfunction

endpackage

### rtl/hll_divider.sv
module hll_divider
	import hll_pkg::*;
#(
	parameter int DenW = SumW
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [127:0]    numer,
	input  logic [DenW-1:0] denom,
	output logic            done,
	output logic [127:0]    quot
);

	logic [127:0]    num_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [7:0]      cnt_q;
	logic            run_q;
	logic [DenW:0]   shifted;
	logic            fits;

	// One quotient bit a cycle, restoring.
	assign shifted = {rem_q[DenW-1:0], num_q[127]};
	assign fits = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 8'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == 8'd127) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quot <= '0;
		end else if (run_q) begin
			num_q <= {num_q[126:0], 1'b0};
			rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
			quot <= {quot[126:0], fits};
		end
	end

endmodule

### rtl/hyperloglog_register_update_estimate.sv
// HyperLogLog register update and estimate. An add command (cmd 0) may issue every cycle
// while busy is low: the rank store is read into a register, then compared and written
// back, with forwarding between back-to-back adds to the same register. An estimate
// (cmd 1) walks the m = 2^p registers one a cycle through the store's read port, p being
// index_bits capped at MAX_INDEX_BITS, then runs a 128-step restoring divider; busy stays
// high meanwhile. Its result appears for one cycle on out_valid; the receiver cannot stall
// and must take it then. After reset a clearing pass over all 2^MAX_INDEX_BITS registers
// holds busy high while the store is zeroed.
module hyperloglog_register_update_estimate
	import hll_pkg::*;
#(
	parameter int MAX_INDEX_BITS = MaxIndexBits
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  hll_in_t  in_data,
	output logic     out_valid,
	output hll_out_t out_data,
	input  logic     cfg_we,
	input  logic     cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int Depth = 1 << MAX_INDEX_BITS;
	localparam int AW = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
	localparam int SumWidth = MAX_INDEX_BITS + 65;

	logic [RankW-1:0] mem [Depth];

	logic [3:0]  index_bits_q;
	logic [15:0] alpha_q;
	hll_state_t  state_q, state_d;
	logic [AW:0] cnt_q;
	logic [4:0]  p;
	logic        accept;

	// Add pipeline.
	logic            add_s1;
	logic [AW-1:0]   addr_s1;
	logic [RankW-1:0] rank_s1;
	logic [RankW-1:0] rd_q;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [RankW-1:0] wr_data;
	logic [RankW-1:0] cur;

	// Sum path.
	logic            sum_s1;
	logic            sum_last_s1;
	logic [SumWidth-1:0] sum_q;
	logic [AW:0]     m;

	logic            div_go, div_go_q, div_done;
	logic [127:0]    numer, quot;
	logic [63:0]     x;

	assign p = ({1'b0, index_bits_q} > 5'(MAX_INDEX_BITS)) ? 5'(MAX_INDEX_BITS)
		: {1'b0, index_bits_q};
	assign m = (AW+1)'(1) << p;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= IndexBitsReset;
			alpha_q <= AlphaReset;
		end else if (cfg_we) begin
			if (cfg_index == RegIndexBits) index_bits_q <= cfg_wdata[3:0];
			else alpha_q <= cfg_wdata;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (cnt_q == (AW+1)'(Depth - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept && in_data.cmd == CmdEstimate) state_d = ST_SUM;
			ST_SUM:   if (sum_last_s1) state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			add_s1 <= 1'b0;
			sum_s1 <= 1'b0;
			sum_last_s1 <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			state_q <= state_d;
			add_s1 <= accept && in_data.cmd == CmdAdd;
			sum_s1 <= (state_q == ST_SUM) && !sum_last_s1 && cnt_q < m;
			sum_last_s1 <= (state_q == ST_SUM) && !sum_last_s1 && cnt_q == m - (AW+1)'(1);
			// Start the divide once the last term has landed in the sum.
			div_go_q <= (state_q == ST_SUM) && sum_last_s1;
			if (state_q == ST_CLEAR || state_q == ST_SUM) cnt_q <= cnt_q + (AW+1)'(1);
			else cnt_q <= '0;
		end
	end

	// Capture add address and rank.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= (p == 5'd0) ? '0 : AW'(in_data.key_hash >> (7'd64 - {2'b0, p}));
			rank_s1 <= rank_of(in_data.key_hash << p);
		end
	end

	// Memory read port: add address or walk address.
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) rd_q <= mem[cnt_q[AW-1:0]];
		else rd_q <= mem[AW'(in_data.key_hash >> (7'd64 - {2'b0, p}))];
	end

	// Forward the previous write to a back-to-back add on the same register.
	logic            fwd_q;
	logic [RankW-1:0] fwd_data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_q <= 1'b0;
		else fwd_q <= accept && add_s1 && wr_addr ==
			((p == 5'd0) ? '0 : AW'(in_data.key_hash >> (7'd64 - {2'b0, p})));
	end
	always_ff @(posedge clk) fwd_data_q <= wr_data;

	assign cur = fwd_q ? fwd_data_q : rd_q;
	assign wr_en = (state_q == ST_CLEAR) || (add_s1 && rank_s1 > cur);
	assign wr_addr = (state_q == ST_CLEAR) ? cnt_q[AW-1:0] : addr_s1;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : (add_s1 && rank_s1 > cur) ? rank_s1 : cur;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	// Accumulate 2^-value with 64 fraction bits.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) sum_q <= '0;
		else if (sum_s1) begin
			if (rd_q == '0) sum_q <= sum_q + (SumWidth'(1) << 64);
			else if (rd_q <= 7'd64) sum_q <= sum_q + (SumWidth'(1) << (7'd64 - rd_q));
		end
	end

	assign x = 64'(alpha_q) << {p, 1'b0};
	assign numer = {x, 64'd0} >> 16;
	assign div_go = div_go_q;

	hll_divider #(
		.DenW(SumWidth)
	) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .numer(numer), .denom(sum_q),
		.done(div_done), .quot(quot)
	);

	// Result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= (state_q == ST_DIV) && div_done;
	end
	always_ff @(posedge clk) begin
		if (div_done) begin
			out_data.saturated <= (sum_q == '0) || (quot[127:64] != '0);
			out_data.estimate <= ((sum_q == '0) || (quot[127:64] != '0)) ? '1 : quot[63:0];
		end
	end

endmodule
